FILE: rtl/vpp_pkg.sv
`default_nettype none

package vpp_pkg;

  // Word format of every vector component
  localparam int WordBits    = 32;
  localparam int FracBitsDef = 16;

  typedef logic signed [WordBits-1:0] vpp_word_t;

  // Input item
  typedef struct packed {
    vpp_word_t vec_x;
    vpp_word_t vec_y;
    vpp_word_t vec_z;
    vpp_word_t norm_x;
    vpp_word_t norm_y;
    vpp_word_t norm_z;
    logic      scaled_mode;
  } vpp_in_t;

  // Result item
  typedef struct packed {
    vpp_word_t proj_x;
    vpp_word_t proj_y;
    vpp_word_t proj_z;
    logic      saturated;
  } vpp_out_t;

  // Projected vector carried alongside the scale computation
  typedef struct packed {
    vpp_word_t x;
    vpp_word_t y;
    vpp_word_t z;
  } vpp_vec_t;

  // Per-item control that travels with the data
  typedef struct packed {
    logic valid;
    logic mode;    // scaled result requested
    logic sat;     // projection was clipped
    logic v_zero;  // |v|^2 is zero
    logic q_ovf;   // scale does not fit the word
  } vpp_ctl_t;

endpackage

`default_nettype wire

FILE: rtl/vpp_scale.sv
`default_nettype none

// Scale extraction: q = floor(p2 * 2^(2F) / v2), one quotient bit per stage,
// then root = floor(sqrt(q)), one root bit per stage.
module vpp_scale import vpp_pkg::*; #(
  parameter int FRAC_BITS = FracBitsDef
) (
  input  wire                      clk_i,
  input  wire                      rst_ni,
  input  wire                      en_i,
  input  vpp_ctl_t                 ctl_i,
  input  vpp_vec_t                 vec_i,
  input  wire  [2*WordBits-1:0]    p2_i,
  input  wire  [2*WordBits-1:0]    v2_i,
  output vpp_ctl_t                 ctl_o,
  output vpp_vec_t                 vec_o,
  output logic [WordBits-1:0]      root_o
);

  localparam int W    = WordBits;
  localparam int W2   = 2 * WordBits;
  localparam int F2   = 2 * FRAC_BITS;
  localparam int RL   = W2 - F2;
  localparam int NDIV = W2;
  localparam int NSQ  = WordBits;

  // Divider stage wires, index 0 is the unit input
  vpp_ctl_t        dv_ctl [NDIV+1];
  vpp_vec_t        dv_vec [NDIV+1];
  logic [W2-1:0]   dv_rem [NDIV+1];
  logic [W2-1:0]   dv_dq  [NDIV+1];
  logic [W2-1:0]   dv_v2  [NDIV+1];

  // Root stage wires, index 0 is the divider output
  vpp_ctl_t        sq_ctl [NSQ+1];
  vpp_vec_t        sq_vec [NSQ+1];
  logic [W-1:0]    sq_rt  [NSQ+1];
  logic [W+1:0]    sq_rem [NSQ+1];
  logic [W2-1:0]   sq_q   [NSQ+1];

  // Remainder starts with the dividend bits above the quotient range
  assign dv_ctl[0] = ctl_i;
  assign dv_vec[0] = vec_i;
  assign dv_rem[0] = W2'(p2_i >> RL);
  assign dv_dq[0]  = {p2_i[RL-1:0], {F2{1'b0}}};
  assign dv_v2[0]  = v2_i;

  // Restoring division, one bit per stage
  for (genvar k = 0; k < NDIV; k++) begin : g_div
    logic [W2:0]   shl;
    logic          ge;
    vpp_ctl_t      ctl_q;
    vpp_vec_t      vec_q;
    logic [W2-1:0] rem_q, rem_d;
    logic [W2-1:0] dq_q, dq_d;
    logic [W2-1:0] v2_q;

    always_comb begin
      shl   = {dv_rem[k], dv_dq[k][W2-1]};
      ge    = (shl >= {1'b0, dv_v2[k]});
      rem_d = ge ? W2'(shl - {1'b0, dv_v2[k]}) : shl[W2-1:0];
      dq_d  = {dv_dq[k][W2-2:0], ge};
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        ctl_q <= '0;
      end else if (en_i) begin
        ctl_q <= dv_ctl[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        vec_q <= dv_vec[k];
        rem_q <= rem_d;
        dq_q  <= dq_d;
        v2_q  <= dv_v2[k];
      end
    end

    assign dv_ctl[k+1] = ctl_q;
    assign dv_vec[k+1] = vec_q;
    assign dv_rem[k+1] = rem_q;
    assign dv_dq[k+1]  = dq_q;
    assign dv_v2[k+1]  = v2_q;
  end

  assign sq_ctl[0] = dv_ctl[NDIV];
  assign sq_vec[0] = dv_vec[NDIV];
  assign sq_rt[0]  = '0;
  assign sq_rem[0] = '0;
  assign sq_q[0]   = dv_dq[NDIV];

  // Digit-by-digit square root, one root bit per stage
  for (genvar m = 0; m < NSQ; m++) begin : g_sqrt
    logic [W+3:0]  r4;
    logic [W+3:0]  trial;
    logic          ge;
    vpp_ctl_t      ctl_q;
    vpp_vec_t      vec_q;
    logic [W-1:0]  rt_q, rt_d;
    logic [W+1:0]  rem_q, rem_d;
    logic [W2-1:0] q_q, q_d;

    always_comb begin
      r4    = {sq_rem[m], sq_q[m][W2-1:W2-2]};
      trial = (W+4)'({sq_rt[m], 2'b01});
      ge    = (r4 >= trial);
      rem_d = ge ? (W+2)'(r4 - trial) : r4[W+1:0];
      rt_d  = {sq_rt[m][W-2:0], ge};
      q_d   = {sq_q[m][W2-3:0], 2'b00};
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        ctl_q <= '0;
      end else if (en_i) begin
        ctl_q <= sq_ctl[m];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        vec_q <= sq_vec[m];
        rt_q  <= rt_d;
        rem_q <= rem_d;
        q_q   <= q_d;
      end
    end

    assign sq_ctl[m+1] = ctl_q;
    assign sq_vec[m+1] = vec_q;
    assign sq_rt[m+1]  = rt_q;
    assign sq_rem[m+1] = rem_q;
    assign sq_q[m+1]   = q_q;
  end

  assign ctl_o  = sq_ctl[NSQ];
  assign vec_o  = sq_vec[NSQ];
  assign root_o = sq_rt[NSQ];

  // A valid in-range division leaves a remainder below the divisor
  a_div_rem: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (dv_ctl[NDIV].valid && dv_ctl[NDIV].mode && !dv_ctl[NDIV].v_zero &&
     !dv_ctl[NDIV].q_ovf) |-> (dv_rem[NDIV] < dv_v2[NDIV]))
    else $error("divider remainder not below divisor");

  // Nothing moves while the pipe is held
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en_i |=> $stable(ctl_o) && $stable(root_o))
    else $error("scale output changed during hold");

endmodule

`default_nettype wire

FILE: rtl/vector_plane_projection.sv
`default_nettype none

// Channel  Dir  Handshake                 Payload
// in       in   in_valid_i / in_ready_o   in_data_i  (vpp_in_t)
// out      out  out_valid_o / out_ready_i out_data_o (vpp_out_t)
//
// One item per cycle unless a waiting result holds the pipe. The scale is formed
// by a divider (one quotient bit per stage) and a root extraction (one root bit
// per stage).
// Reset clears only the valid bits and control words; the data path has no reset.
// When a result waits untaken, the whole pipe holds; nothing is lost or repeated.
module vector_plane_projection import vpp_pkg::*; #(
  parameter int FRAC_BITS = FracBitsDef
) (
  input  wire      clk_i,
  input  wire      rst_ni,
  input  wire      in_valid_i,
  output logic     in_ready_o,
  input  vpp_in_t  in_data_i,
  output logic     out_valid_o,
  input  wire      out_ready_i,
  output vpp_out_t out_data_o
);

  localparam int W   = WordBits;
  localparam int F   = FRAC_BITS;
  localparam int W2  = 2 * WordBits;
  localparam int TW  = W2 + 1 - F;      // rounded n x v
  localparam int TL  = (TW + 1) / 2;    // low split of t, unsigned
  localparam int TH  = TW - TL;         // high split of t, signed
  localparam int PW  = W + TW;          // full n * t product
  localparam int RPW = PW + 2 - F;      // rounded projection
  localparam int RSW = W2 + 2 - F;      // rounded scaled component
  localparam int SH  = W2 - 2 * F;      // ovf compare shift
  localparam int CW  = W2 + SH;

  localparam logic [W-1:0] MaxW = {1'b0, {(W-1){1'b1}}};
  localparam logic [W-1:0] MinW = {1'b1, {(W-1){1'b0}}};

  // Clip helpers, flag in the top bit
  function automatic logic [W:0] sat_rpw(input logic [RPW-1:0] x);
    logic [RPW-W:0] top;
    top = x[RPW-1:W-1];
    if ((&top) || !(|top)) return {1'b0, x[W-1:0]};
    return {1'b1, x[RPW-1] ? MinW : MaxW};
  endfunction

  function automatic logic [W:0] sat_rsw(input logic [RSW-1:0] x);
    logic [RSW-W:0] top;
    top = x[RSW-1:W-1];
    if ((&top) || !(|top)) return {1'b0, x[W-1:0]};
    return {1'b1, x[RSW-1] ? MinW : MaxW};
  endfunction

  logic adv;
  logic out_vld_q;

  // Global advance: the output register is free or being taken
  assign adv        = !out_vld_q || out_ready_i;
  assign in_ready_o = adv;

  logic signed [W-1:0] in_v [3];
  logic signed [W-1:0] in_n [3];

  assign in_v[0] = in_data_i.vec_x;
  assign in_v[1] = in_data_i.vec_y;
  assign in_v[2] = in_data_i.vec_z;
  assign in_n[0] = in_data_i.norm_x;
  assign in_n[1] = in_data_i.norm_y;
  assign in_n[2] = in_data_i.norm_z;

  // Stage registers
  logic b_vld_q, c_vld_q, d_vld_q, e_vld_q, f_vld_q, g_vld_q, h_vld_q;
  logic b_mode_q, c_mode_q, d_mode_q, e_mode_q, f_mode_q, g_mode_q, h_mode_q;

  logic signed [W2-1:0] b_pa_q [3];
  logic signed [W2-1:0] b_pb_q [3];
  logic        [W2-1:0] b_sq_q [3];
  logic signed [W-1:0]  b_n_q  [3];

  logic signed [TW-1:0] c_t_q  [3];
  logic signed [W-1:0]  c_n_q  [3];
  logic        [W2-1:0] c_v2_q;

  logic signed [W+TL:0]   d_lo_a_q [3];
  logic signed [W+TH-1:0] d_hi_a_q [3];
  logic signed [W+TL:0]   d_lo_b_q [3];
  logic signed [W+TH-1:0] d_hi_b_q [3];
  logic        [W2-1:0]   d_v2_q;

  logic signed [PW-1:0] e_pa_q [3];
  logic signed [PW-1:0] e_pb_q [3];
  logic        [W2-1:0] e_v2_q;
  logic                 e_vz_q;

  logic signed [W-1:0]  f_p_q [3];
  logic                 f_sat_q;
  logic        [W2-1:0] f_v2_q;
  logic                 f_vz_q;

  logic        [W2-1:0] g_sq_q [3];
  logic signed [W-1:0]  g_p_q  [3];
  logic                 g_sat_q;
  logic        [W2-1:0] g_v2_q;
  logic                 g_vz_q;

  logic        [W2-1:0] h_p2_q;
  logic signed [W-1:0]  h_p_q [3];
  logic                 h_sat_q;
  logic        [W2-1:0] h_v2_q;
  logic                 h_vz_q;

  vpp_ctl_t             i_ctl_q;
  vpp_vec_t             i_p_q;
  logic        [W2-1:0] i_p2_q;
  logic        [W2-1:0] i_v2_q;

  vpp_ctl_t             s_ctl;
  vpp_vec_t             s_p;
  logic        [W-1:0]  s_root;

  vpp_ctl_t             j_ctl_q;
  logic signed [W-1:0]  j_p_q    [3];
  logic signed [W2:0]   j_prod_q [3];

  vpp_ctl_t             k_ctl_q;
  vpp_out_t             out_q, out_d;

  logic signed [TW-1:0] c_t_d  [3];
  logic signed [PW-1:0] e_pa_d [3];
  logic signed [PW-1:0] e_pb_d [3];
  logic signed [W-1:0]  f_p_d  [3];
  logic        [2:0]    f_clip;
  logic signed [W-1:0]  k_p_d  [3];
  logic        [2:0]    k_clip;
  logic signed [W-1:0]  s_p_w  [3];
  logic        [W:0]    s_ext;

  // Valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_vld_q   <= 1'b0;
      c_vld_q   <= 1'b0;
      d_vld_q   <= 1'b0;
      e_vld_q   <= 1'b0;
      f_vld_q   <= 1'b0;
      g_vld_q   <= 1'b0;
      h_vld_q   <= 1'b0;
      i_ctl_q   <= '0;
      j_ctl_q   <= '0;
      k_ctl_q   <= '0;
      out_vld_q <= 1'b0;
    end else if (adv) begin
      b_vld_q         <= in_valid_i;
      c_vld_q         <= b_vld_q;
      d_vld_q         <= c_vld_q;
      e_vld_q         <= d_vld_q;
      f_vld_q         <= e_vld_q;
      g_vld_q         <= f_vld_q;
      h_vld_q         <= g_vld_q;
      i_ctl_q.valid   <= h_vld_q;
      i_ctl_q.mode    <= h_mode_q;
      i_ctl_q.sat     <= h_sat_q;
      i_ctl_q.v_zero  <= h_vz_q;
      i_ctl_q.q_ovf   <= (CW'(h_p2_q) >= {h_v2_q, {SH{1'b0}}});
      j_ctl_q         <= s_ctl;
      k_ctl_q         <= j_ctl_q;
      out_vld_q       <= j_ctl_q.valid;
    end
  end

  // Per-component data path
  for (genvar i = 0; i < 3; i++) begin : g_lane
    localparam int I1 = (i + 1) % 3;
    localparam int I2 = (i + 2) % 3;

    logic signed [W2+1:0]  t_sum;
    logic signed [PW+1:0]  pr_sum;
    logic        [W:0]     p_sat;
    logic signed [W2+1:0]  k_sum;
    logic        [W:0]     k_sat;

    // t = n x v, rounded
    always_comb begin
      t_sum    = (W2+2)'(b_pa_q[i]) - (W2+2)'(b_pb_q[i]) + (W2+2)'(1 << (F - 1));
      c_t_d[i] = t_sum[F+TW-1:F];
    end

    // n * t from two partial products
    always_comb begin
      e_pa_d[i] = $signed({d_hi_a_q[i], {TL{1'b0}}}) + PW'(d_lo_a_q[i]);
      e_pb_d[i] = $signed({d_hi_b_q[i], {TL{1'b0}}}) + PW'(d_lo_b_q[i]);
    end

    // p = (-n) x t, rounded and clipped
    always_comb begin
      pr_sum    = (PW+2)'(e_pa_q[i]) - (PW+2)'(e_pb_q[i]) + (PW+2)'(1 << (F - 1));
      p_sat     = sat_rpw(pr_sum[PW+1:F]);
      f_p_d[i]  = p_sat[W-1:0];
      f_clip[i] = p_sat[W];
    end

    // p * s, rounded and clipped
    always_comb begin
      k_sum     = (W2+2)'(j_prod_q[i]) + (W2+2)'(1 << (F - 1));
      k_sat     = sat_rsw(k_sum[W2+1:F]);
      k_p_d[i]  = k_sat[W-1:0];
      k_clip[i] = k_sat[W];
    end

    always_ff @(posedge clk_i) begin
      if (adv) begin
        b_pa_q[i]   <= in_n[I1] * in_v[I2];
        b_pb_q[i]   <= in_n[I2] * in_v[I1];
        b_sq_q[i]   <= W2'(in_v[i] * in_v[i]);
        b_n_q[i]    <= in_n[i];
        c_t_q[i]    <= c_t_d[i];
        c_n_q[i]    <= b_n_q[i];
        d_lo_a_q[i] <= c_n_q[I2] * $signed({1'b0, c_t_q[I1][TL-1:0]});
        d_hi_a_q[i] <= c_n_q[I2] * $signed(c_t_q[I1][TW-1:TL]);
        d_lo_b_q[i] <= c_n_q[I1] * $signed({1'b0, c_t_q[I2][TL-1:0]});
        d_hi_b_q[i] <= c_n_q[I1] * $signed(c_t_q[I2][TW-1:TL]);
        e_pa_q[i]   <= e_pa_d[i];
        e_pb_q[i]   <= e_pb_d[i];
        f_p_q[i]    <= f_p_d[i];
        g_sq_q[i]   <= W2'(f_p_q[i] * f_p_q[i]);
        g_p_q[i]    <= f_p_q[i];
        h_p_q[i]    <= g_p_q[i];
        j_p_q[i]    <= s_p_w[i];
        j_prod_q[i] <= s_p_w[i] * $signed(s_ext);
      end
    end
  end

  // Shared data registers
  always_ff @(posedge clk_i) begin
    if (adv) begin
      b_mode_q <= in_data_i.scaled_mode;
      c_mode_q <= b_mode_q;
      c_v2_q   <= b_sq_q[0] + b_sq_q[1] + b_sq_q[2];
      d_mode_q <= c_mode_q;
      d_v2_q   <= c_v2_q;
      e_mode_q <= d_mode_q;
      e_v2_q   <= d_v2_q;
      e_vz_q   <= (d_v2_q == '0);
      f_mode_q <= e_mode_q;
      f_v2_q   <= e_v2_q;
      f_vz_q   <= e_vz_q;
      f_sat_q  <= |f_clip;
      g_mode_q <= f_mode_q;
      g_v2_q   <= f_v2_q;
      g_vz_q   <= f_vz_q;
      g_sat_q  <= f_sat_q;
      h_mode_q <= g_mode_q;
      h_v2_q   <= g_v2_q;
      h_vz_q   <= g_vz_q;
      h_sat_q  <= g_sat_q;
      h_p2_q   <= g_sq_q[0] + g_sq_q[1] + g_sq_q[2];
      i_p_q.x  <= h_p_q[0];
      i_p_q.y  <= h_p_q[1];
      i_p_q.z  <= h_p_q[2];
      i_p2_q   <= h_p2_q;
      i_v2_q   <= h_v2_q;
      out_q    <= out_d;
    end
  end

  // Scale = floor(sqrt(p2 * 2^(2F) / v2))
  vpp_scale #(
    .FRAC_BITS(FRAC_BITS)
  ) u_scale (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (adv),
    .ctl_i  (i_ctl_q),
    .vec_i  (i_p_q),
    .p2_i   (i_p2_q),
    .v2_i   (i_v2_q),
    .ctl_o  (s_ctl),
    .vec_o  (s_p),
    .root_o (s_root)
  );

  // Scale held at all ones when it does not fit
  always_comb begin
    s_p_w[0] = s_p.x;
    s_p_w[1] = s_p.y;
    s_p_w[2] = s_p.z;
    s_ext    = {1'b0, (s_ctl.q_ovf ? {W{1'b1}} : s_root)};
  end

  // Result select
  always_comb begin
    if (!j_ctl_q.mode) begin
      out_d.proj_x    = j_p_q[0];
      out_d.proj_y    = j_p_q[1];
      out_d.proj_z    = j_p_q[2];
      out_d.saturated = j_ctl_q.sat;
    end else if (j_ctl_q.v_zero) begin
      out_d = '0;
    end else begin
      out_d.proj_x    = k_p_d[0];
      out_d.proj_y    = k_p_d[1];
      out_d.proj_z    = k_p_d[2];
      out_d.saturated = j_ctl_q.sat || j_ctl_q.q_ovf || (|k_clip);
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

  // Mode 1 with a zero vector gives a clean zero result
  a_zero_vec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && k_ctl_q.valid && k_ctl_q.mode && k_ctl_q.v_zero) |->
      (out_q == '0))
    else $error("zero vector result not cleared");

  // An oversized scale in mode 1 with a nonzero vector always reports clipping
  a_ovf_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && k_ctl_q.mode && !k_ctl_q.v_zero && k_ctl_q.q_ovf) |->
      out_q.saturated)
    else $error("scale overflow without saturated flag");

  // Output valid follows the item carried in the last control stage
  a_out_track: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q |-> k_ctl_q.valid)
    else $error("output valid without a tracked item");

endmodule

`default_nettype wire

FILE: tb/vector_plane_projection_check.sv
`timescale 1ns / 1ps

module vector_plane_projection_check import vpp_pkg::*; #(
  parameter int FRAC_BITS = FracBitsDef
) (
  input  wire      clk_i,
  input  wire      in_valid_i,
  input  wire      in_ready_i,
  input  vpp_in_t  in_data_i,
  input  wire      out_valid_i,
  input  wire      out_ready_i,
  input  vpp_out_t out_data_i,
  output int       fail_count_o,
  output int       pending_o,
  output int       checked_o,
  output int       scaled_seen_o,
  output int       clipped_seen_o
);

  // Wide enough for scale candidate squared times |v|^2
  typedef logic signed [255:0] wide_t;

  vpp_out_t proj_q[$];

  function automatic wide_t round_frac(wide_t a);
    wide_t half;
    half = wide_t'(1) <<< (FRAC_BITS - 1);
    return (a + half) >>> FRAC_BITS;
  endfunction

  function automatic vpp_word_t clip_word(wide_t a, inout logic clipped);
    wide_t hi, lo;
    hi = (wide_t'(1) <<< (WordBits - 1)) - 1;
    lo = -(wide_t'(1) <<< (WordBits - 1));
    if (a > hi) begin
      clipped = 1'b1;
      return vpp_word_t'(hi);
    end
    if (a < lo) begin
      clipped = 1'b1;
      return vpp_word_t'(lo);
    end
    return vpp_word_t'(a);
  endfunction

  // Expected projection of one input item
  function automatic vpp_out_t project(vpp_in_t d);
    wide_t v[3], n[3], t[3], pr[3], p[3];
    wide_t p2, v2, lhs, cand, s, top;
    vpp_word_t pw[3];
    logic clipped;
    vpp_out_t r;
    v[0] = d.vec_x;  v[1] = d.vec_y;  v[2] = d.vec_z;
    n[0] = d.norm_x; n[1] = d.norm_y; n[2] = d.norm_z;
    clipped = 1'b0;
    // t = n x v, rounded, never clipped
    t[0] = round_frac(n[1] * v[2] - v[1] * n[2]);
    t[1] = round_frac(v[0] * n[2] - n[0] * v[2]);
    t[2] = round_frac(n[0] * v[1] - v[0] * n[1]);
    // p = (-n) x t
    pr[0] = (-n[1]) * t[2] - t[1] * (-n[2]);
    pr[1] = t[0] * (-n[2]) - (-n[0]) * t[2];
    pr[2] = (-n[0]) * t[1] - t[0] * (-n[1]);
    for (int i = 0; i < 3; i++) pw[i] = clip_word(round_frac(pr[i]), clipped);
    if (!d.scaled_mode) begin
      r.proj_x = pw[0]; r.proj_y = pw[1]; r.proj_z = pw[2];
      r.saturated = clipped;
      return r;
    end
    p2 = 0;
    v2 = 0;
    for (int i = 0; i < 3; i++) begin
      p[i] = pw[i];
      p2 += p[i] * p[i];
      v2 += v[i] * v[i];
    end
    if (v2 == 0) return '0;
    lhs = p2 <<< (2 * FRAC_BITS);
    // Bitwise integer square root of the ratio
    s = 0;
    for (int b = WordBits - 1; b >= 0; b--) begin
      cand = s | (wide_t'(1) <<< b);
      if (cand * cand * v2 <= lhs) s = cand;
    end
    top = wide_t'(1) <<< WordBits;
    if (top * top * v2 <= lhs) clipped = 1'b1;
    r.proj_x = clip_word(round_frac(p[0] * s), clipped);
    r.proj_y = clip_word(round_frac(p[1] * s), clipped);
    r.proj_z = clip_word(round_frac(p[2] * s), clipped);
    r.saturated = clipped;
    return r;
  endfunction

  initial begin
    fail_count_o = 0;
    checked_o = 0;
    scaled_seen_o = 0;
    clipped_seen_o = 0;
  end

  assign pending_o = proj_q.size();

  // Predict on input transfer, compare on output transfer
  always @(posedge clk_i) begin
    vpp_out_t want;
    if (in_valid_i && in_ready_i) begin
      proj_q.push_back(project(in_data_i));
      if (in_data_i.scaled_mode) scaled_seen_o++;
    end
    if (out_valid_i && out_ready_i) begin
      if (proj_q.size() == 0) begin
        $display("%0t: unexpected result %h", $time, out_data_i);
        fail_count_o++;
      end else begin
        want = proj_q.pop_front();
        checked_o++;
        if (want.saturated) clipped_seen_o++;
        if (out_data_i.proj_x !== want.proj_x) begin
          $display("%0t: proj_x expected %h got %h", $time, want.proj_x, out_data_i.proj_x);
          fail_count_o++;
        end
        if (out_data_i.proj_y !== want.proj_y) begin
          $display("%0t: proj_y expected %h got %h", $time, want.proj_y, out_data_i.proj_y);
          fail_count_o++;
        end
        if (out_data_i.proj_z !== want.proj_z) begin
          $display("%0t: proj_z expected %h got %h", $time, want.proj_z, out_data_i.proj_z);
          fail_count_o++;
        end
        if (out_data_i.saturated !== want.saturated) begin
          $display("%0t: saturated expected %b got %b", $time, want.saturated,
                   out_data_i.saturated);
          fail_count_o++;
        end
      end
    end
  end

endmodule

FILE: tb/vector_plane_projection_test.sv
`timescale 1ns / 1ps

module vector_plane_projection_test;
  import vpp_pkg::*;

  localparam int RandItems = 800;
  localparam int Latency   = 3 * WordBits + 10;
  localparam int CycleCap  = 400000;
  localparam int Unit      = 1 << FracBitsDef;

  logic     clk = 1'b0;
  logic     rst_n = 1'b0;
  logic     in_valid = 1'b0;
  logic     in_ready;
  vpp_in_t  in_data = '0;
  logic     out_valid;
  logic     out_ready = 1'b0;
  vpp_out_t out_data;
  int       fail_count, pending, checked, scaled_seen, clipped_seen;
  int       cycles = 0;
  logic     no_gaps = 1'b0;

  always #2 clk = ~clk;

  vector_plane_projection dut (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_ready_o(in_ready), .in_data_i(in_data),
    .out_valid_o(out_valid), .out_ready_i(out_ready), .out_data_o(out_data)
  );

  vector_plane_projection_check check (
    .clk_i(clk),
    .in_valid_i(in_valid), .in_ready_i(in_ready), .in_data_i(in_data),
    .out_valid_i(out_valid), .out_ready_i(out_ready), .out_data_i(out_data),
    .fail_count_o(fail_count), .pending_o(pending), .checked_o(checked),
    .scaled_seen_o(scaled_seen), .clipped_seen_o(clipped_seen)
  );

  // Watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleCap) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // Result side: random stall before each transfer
  initial begin
    int stall;
    @(posedge rst_n);
    forever begin
      stall = no_gaps ? 0 : $urandom_range(0, 14);
      repeat (stall) begin
        @(negedge clk);
        out_ready = 1'b0;
      end
      @(negedge clk);
      out_ready = 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  // One input transfer after a random gap
  task automatic send(vpp_in_t d);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 14);
    repeat (gap) begin
      @(negedge clk);
      in_valid = 1'b0;
    end
    @(negedge clk);
    in_valid = 1'b1;
    in_data = d;
    do @(posedge clk); while (!in_ready);
  endtask

  function automatic vpp_in_t make(int vx, int vy, int vz, int nx, int ny, int nz,
                                   logic mode);
    vpp_in_t d;
    d.vec_x = vx;  d.vec_y = vy;  d.vec_z = vz;
    d.norm_x = nx; d.norm_y = ny; d.norm_z = nz;
    d.scaled_mode = mode;
    return d;
  endfunction

  function automatic vpp_word_t rnd_small();
    return vpp_word_t'($signed($urandom_range(0, 1 << 22)) - (1 << 21));
  endfunction

  // Mostly plausible geometry, some raw full-range words
  function automatic vpp_in_t rnd_item();
    vpp_in_t d;
    int axis;
    d = vpp_in_t'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                   $urandom});
    case ($urandom_range(0, 3))
      0: ;
      1: begin
        d.vec_x = rnd_small(); d.vec_y = rnd_small(); d.vec_z = rnd_small();
        d.norm_x = rnd_small() >>> 4; d.norm_y = rnd_small() >>> 4;
        d.norm_z = rnd_small() >>> 4;
      end
      default: begin
        d.vec_x = rnd_small(); d.vec_y = rnd_small(); d.vec_z = rnd_small();
        d.norm_x = '0; d.norm_y = '0; d.norm_z = '0;
        axis = $urandom_range(0, 2);
        if (axis == 0) d.norm_x = $urandom_range(0, 1) ? Unit : -Unit;
        if (axis == 1) d.norm_y = $urandom_range(0, 1) ? Unit : -Unit;
        if (axis == 2) d.norm_z = $urandom_range(0, 1) ? Unit : -Unit;
        d.norm_x += $signed($urandom_range(0, 512)) - 256;
      end
    endcase
    return d;
  endfunction

  initial begin
    int mx, mn;
    mx = 32'h7fffffff;
    mn = 32'h80000000;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed: unit normals, zero vectors, extremes, clipping, scale overflow
    for (int m = 0; m < 2; m++) begin
      send(make(0, 0, 0, Unit, 0, 0, m[0]));
      send(make(Unit, 2 * Unit, 3 * Unit, 0, 0, Unit, m[0]));
      send(make(-Unit, Unit, 5 * Unit, Unit, 0, 0, m[0]));
      send(make(3 * Unit, -4 * Unit, 7, 0, -Unit, 0, m[0]));
      send(make(mx, mx, mx, mx, mx, mx, m[0]));
      send(make(mn, mn, mn, mn, mn, mn, m[0]));
      send(make(mx, mn, mx, mn, mx, mn, m[0]));
      send(make(1, 0, 0, 0, mx, 0, m[0]));
      send(make(Unit, 0, 0, 0, 64 * Unit, 0, m[0]));
      send(make(Unit, Unit, 0, Unit, 0, 0, m[0]));
      send(make(mx, 0, 0, Unit, 0, 0, m[0]));
    end
    send(make(0, 0, 0, 0, 0, 0, 1'b1));

    // Random, with gap-free stretches now and then
    for (int i = 0; i < RandItems; i++) begin
      if (i % 100 == 0) no_gaps = ($urandom_range(0, 2) == 0);
      send(rnd_item());
    end
    @(negedge clk);
    in_valid = 1'b0;
    no_gaps = 1'b0;

    while (pending != 0) @(posedge clk);
    repeat (Latency + 20) @(posedge clk);

    $display("Checked %0d projections (%0d scaled, %0d with clipping),", checked,
             scaled_seen, clipped_seen);
    $display("with random gaps on both channels and gap-free stretches.");
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
